// ----- rtl/pointer_contact_tracker_macros.svh -----
// Assertion macros for the pointer contact tracker.
`ifndef POINTER_CONTACT_TRACKER_MACROS_SVH
`define POINTER_CONTACT_TRACKER_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define PCT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define PCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pct_pkg.sv -----
// Shared constants, codes and types of the pointer contact tracker.
package pct_pkg;

  localparam int ID_COUNT     = 256;
  localparam int PAYLOAD_BITS = 32;

  localparam int ID_W     = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int IDENT_W  = 8;
  localparam int MODE_W   = 2;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int PTYPE_W  = 2;
  localparam int HANDLE_W = 32;
  localparam int OPAY_W   = 32;
  localparam int COUNT_W  = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_EVENT = 2'd0,
    MODE_SWEEP = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    K_TOUCH_START  = 3'd0,
    K_TOUCH_MOVE   = 3'd1,
    K_TOUCH_END    = 3'd2,
    K_TOUCH_CANCEL = 3'd3,
    K_MOUSE_DOWN   = 3'd4,
    K_MOUSE_MOVE   = 3'd5,
    K_MOUSE_UP     = 3'd6,
    K_HOVER_MOVE   = 3'd7
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_IGNORED  = 3'd2,
    STAT_SWEPT    = 3'd3,
    STAT_HIT      = 3'd4,
    STAT_MISS     = 3'd5
  } status_e;

  typedef enum logic [PTYPE_W-1:0] {
    PT_NONE  = 2'd0,
    PT_TOUCH = 2'd1,
    PT_MOUSE = 2'd2
  } ptype_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SWEEP
  } state_e;

  typedef struct packed {
    logic [PTYPE_W-1:0]      ptype;
    logic [KIND_W-1:0]       kind;
    logic [PAYLOAD_BITS-1:0] payload;
  } info_t;

  // End, cancel or up: entry is dropped at the next frame sweep.
  function automatic logic is_terminal(logic [KIND_W-1:0] k);
    return (k == K_TOUCH_END) || (k == K_TOUCH_CANCEL) || (k == K_MOUSE_UP);
  endfunction

  // Start or mouse down: only ever creates, never updates.
  function automatic logic is_start(logic [KIND_W-1:0] k);
    return (k == K_TOUCH_START) || (k == K_MOUSE_DOWN);
  endfunction

  function automatic logic [PTYPE_W-1:0] ptype_of(logic [KIND_W-1:0] k);
    logic [PTYPE_W-1:0] p;
    case (k)
      K_TOUCH_START: p = PT_TOUCH;
      K_MOUSE_DOWN:  p = PT_MOUSE;
      default:       p = PT_NONE;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/pct_intf.sv -----
// Valid/ready channel interfaces for tracker items and results.
interface pct_in_if;
  import pct_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [KIND_W-1:0]   event_kind;
  logic [IDENT_W-1:0]  identifier;
  logic [OPAY_W-1:0]   event_payload;

  modport source (output valid, mode, event_kind, identifier, event_payload,
                  input ready);
  modport sink   (input valid, mode, event_kind, identifier, event_payload,
                  output ready);
endinterface

interface pct_out_if;
  import pct_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle;
  logic [PTYPE_W-1:0]  pointer_type;
  logic [KIND_W-1:0]   last_kind;
  logic [OPAY_W-1:0]   last_payload;
  logic [COUNT_W-1:0]  removed_count;

  modport source (output valid, status, handle, pointer_type, last_kind,
                  last_payload, removed_count, input ready);
  modport sink   (input valid, status, handle, pointer_type, last_kind,
                  last_payload, removed_count, output ready);
endinterface

// ----- rtl/pointer_contact_tracker.sv -----
// Pointer contact tracker: per-identifier table of touch and mouse pointers.
//
//  channel | dir | transfer moves                                 | handshake
//  --------+-----+------------------------------------------------+----------
//  in_i    | in  | mode, event_kind, identifier, event_payload    | valid/ready
//  out_o   | out | status, handle, pointer_type, last_kind,       | valid/ready
//          |     | last_payload, removed_count                    |
//
// Event and query items: table read at the transfer, then read-modify-write and
//   result load in the lookup stage once the output register is free; one item in flight.
// A frame sweep reads the info memory one entry per cycle and checks each entry
//   in the cycle after its read.
// Reset clears the valid flags and sets the handle counter to one at once;
//   the handle and info memories are not cleared (only valid entries are read).
// A stalled result sits in the output register; the next item is still taken
//   and waits in the lookup stage until the output register frees up.
module pointer_contact_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  pct_in_if.sink        in_i,
  pct_out_if.source     out_o
);
  import pct_pkg::*;

  localparam logic [ID_W-1:0] ID_LAST = ID_W'(ID_COUNT - 1);

  // Control
  state_e state_q, state_d;

  // Item held during lookup
  logic [MODE_W-1:0]       mode_q;
  logic [KIND_W-1:0]       kind_q;
  logic [ID_W-1:0]         idx_q;
  logic                    id_ok_q;
  logic [PAYLOAD_BITS-1:0] payload_q;

  // Table storage: valid flags in flops, the rest in memories
  logic [ID_COUNT-1:0]     valid_q, valid_d;
  logic [HANDLE_W-1:0]     handle_mem [ID_COUNT];
  info_t                   info_mem   [ID_COUNT];
  logic [HANDLE_W-1:0]     rd_handle_q;
  info_t                   rd_info_q;
  logic [ID_W-1:0]         rd_idx;
  logic [HANDLE_W-1:0]     next_handle_q;

  // Sweep walker: read address, then the entry being checked in the next cycle
  logic [ID_W-1:0]         sweep_idx_q, sweep_idx_d;
  logic                    sweep_chk_q;
  logic [ID_W-1:0]         sweep_chk_idx_q;
  logic [COUNT_W-1:0]      removed_q, removed_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     out_status_q;
  logic [HANDLE_W-1:0]     out_handle_q;
  logic [PTYPE_W-1:0]      out_ptype_q;
  logic [KIND_W-1:0]       out_kind_q;
  logic [OPAY_W-1:0]       out_payload_q;
  logic [COUNT_W-1:0]      out_count_q;

  // Datapath
  logic                    in_fire, out_fire, out_free, finish;
  logic                    in_id_ok;
  logic [ID_W-1:0]         in_idx;
  logic                    hit, do_ins, do_upd, sweep_drop;
  info_t                   wr_info;
  logic [STATUS_W-1:0]     res_status;
  logic [HANDLE_W-1:0]     res_handle;
  logic [PTYPE_W-1:0]      res_ptype;
  logic [KIND_W-1:0]       res_kind;
  logic [OPAY_W-1:0]       res_payload;
  logic [COUNT_W-1:0]      res_count;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = out_o.valid & out_o.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Identifiers past the table depth never hit and never create.
  assign in_id_ok = ({1'b0, in_i.identifier} < (IDENT_W + 1)'(ID_COUNT));
  assign in_idx   = in_i.identifier[ID_W-1:0];

  // Info memory address: the walker during a sweep, else the incoming item.
  assign rd_idx = (state_q == S_SWEEP) ? sweep_idx_q : in_idx;

  assign hit = id_ok_q && valid_q[idx_q];

  // Entry read last cycle by the walker: drop it if live and closed.
  assign sweep_drop = sweep_chk_q && valid_q[sweep_chk_idx_q] && is_terminal(rd_info_q.kind);

  // Result and table update decisions of the lookup stage
  always_comb begin
    do_ins      = 1'b0;
    do_upd      = 1'b0;
    res_status  = STAT_IGNORED;
    res_handle  = '0;
    res_ptype   = '0;
    res_kind    = '0;
    res_payload = '0;
    res_count   = '0;
    wr_info     = rd_info_q;
    case (mode_q)
      MODE_EVENT: begin
        if (id_ok_q && !valid_q[idx_q] && (is_start(kind_q) || kind_q == K_HOVER_MOVE)) begin
          do_ins        = 1'b1;
          wr_info.ptype = ptype_of(kind_q);
          res_status    = STAT_INSERTED;
          res_handle    = next_handle_q;
        end else if (hit && !is_start(kind_q)) begin
          do_upd     = 1'b1;
          res_status = STAT_UPDATED;
          res_handle = rd_handle_q;
        end
        wr_info.kind    = kind_q;
        wr_info.payload = payload_q;
        if (do_ins || do_upd) begin
          res_ptype   = wr_info.ptype;
          res_kind    = kind_q;
          res_payload = OPAY_W'(payload_q);
        end
      end
      MODE_SWEEP: begin
        res_status = STAT_SWEPT;
        res_count  = removed_q;
      end
      MODE_QUERY: begin
        if (hit) begin
          res_status  = STAT_HIT;
          res_handle  = rd_handle_q;
          res_ptype   = rd_info_q.ptype;
          res_kind    = rd_info_q.kind;
          res_payload = OPAY_W'(rd_info_q.payload);
        end else begin
          res_status = STAT_MISS;
        end
      end
      default: res_status = STAT_IGNORED;
    endcase
  end

  // Next state, flag updates, sweep walker and output register control
  always_comb begin
    state_d     = state_q;
    finish      = 1'b0;
    valid_d     = valid_q;
    sweep_idx_d = sweep_idx_q;
    removed_d   = removed_q;
    if (sweep_drop) begin
      valid_d[sweep_chk_idx_q] = 1'b0;
      removed_d                = removed_q + COUNT_W'(1);
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.mode == MODE_SWEEP) begin
            state_d     = S_SWEEP;
            sweep_idx_d = '0;
            removed_d   = '0;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_SWEEP: begin
        if (sweep_idx_q == ID_LAST) begin
          state_d = S_LOOK;
        end else begin
          sweep_idx_d = sweep_idx_q + ID_W'(1);
        end
      end
      S_LOOK: begin
        // After a sweep the last entry is still checked in the first cycle here.
        if (out_free && !sweep_chk_q) begin
          finish  = 1'b1;
          state_d = S_IDLE;
          if (do_ins) begin
            valid_d[idx_q] = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = finish ? 1'b1 : (out_fire ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      valid_q       <= '0;
      next_handle_q <= HANDLE_W'(1);
      out_valid_q   <= 1'b0;
      sweep_idx_q   <= '0;
      sweep_chk_q   <= 1'b0;
      removed_q     <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      sweep_idx_q <= sweep_idx_d;
      sweep_chk_q <= (state_q == S_SWEEP);
      removed_q   <= removed_d;
      if (finish && do_ins) begin
        next_handle_q <= next_handle_q + HANDLE_W'(1);
      end
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= in_i.mode;
      kind_q    <= in_i.event_kind;
      idx_q     <= in_idx;
      id_ok_q   <= in_id_ok;
      payload_q <= in_i.event_payload[PAYLOAD_BITS-1:0];
    end
    if (state_q == S_SWEEP) begin
      sweep_chk_idx_q <= sweep_idx_q;
    end
    if (finish) begin
      out_status_q  <= res_status;
      out_handle_q  <= res_handle;
      out_ptype_q   <= res_ptype;
      out_kind_q    <= res_kind;
      out_payload_q <= res_payload;
      out_count_q   <= res_count;
    end
  end

  // Table memories: one read at the input transfer or per sweep step,
  // one write at finish
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_handle_q <= handle_mem[in_idx];
    end
    if (in_fire || state_q == S_SWEEP) begin
      rd_info_q <= info_mem[rd_idx];
    end
    if (finish && do_ins) begin
      handle_mem[idx_q] <= next_handle_q;
    end
    if (finish && (do_ins || do_upd)) begin
      info_mem[idx_q] <= wr_info;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.handle        = out_handle_q;
  assign out_o.pointer_type  = out_ptype_q;
  assign out_o.last_kind     = out_kind_q;
  assign out_o.last_payload  = out_payload_q;
  assign out_o.removed_count = out_count_q;

  // Checks
`include "pointer_contact_tracker_macros.svh"

  `PCT_ASSERT(a_handle_only_on_insert, clk_i, rst_ni, (next_handle_q == $past(next_handle_q)) || $past(finish && do_ins), "handle counter moved without an insert")
  `PCT_ASSERT(a_result_from_lookup, clk_i, rst_ni, !$rose(out_valid_q) || $past(state_q == S_LOOK), "result appeared outside the lookup stage")
  `PCT_ASSERT_IMP(a_count_only_swept, clk_i, rst_ni, out_o.valid && (out_o.removed_count != '0), out_o.status == STAT_SWEPT, "removed count on a non-sweep result")
  `PCT_ASSERT_IMP(a_no_take_in_sweep, clk_i, rst_ni, state_q == S_SWEEP, !in_i.ready, "input taken during a frame sweep")

endmodule

// ----- sim/tb_pointer_contact_tracker.sv -----
// Testbench for the pointer contact tracker: directed table, then random traffic, scoreboarded.
`timescale 1ns / 1ps

module tb_pointer_contact_tracker;
  import pct_pkg::*;

  // Mode 3 has no package name; the tracker must answer it as ignored.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 1300;
  // Long back-pressure stretch on the result side, in cycles.
  localparam int HOLD_CYCLES   = 400;
  // Cycles without any transfer before the run is declared hung. The worst
  // legal gap is a sweep overlapping the long hold.
  localparam int STALL_LIMIT   = 4000;
  // Quiet time after the last result: longer than one full sweep.
  localparam int SETTLE_CYCLES = ID_COUNT + 10;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    kind_e              kind;
    logic [IDENT_W-1:0] ident;
    logic [OPAY_W-1:0]  payload;
  } ptr_item_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    ptype_e              ptype;
    kind_e               kind;
    logic [OPAY_W-1:0]   payload;
    logic [COUNT_W-1:0]  removed;
  } ptr_report_t;

  // One row of the directed table. When typed is set the report was read
  // off by hand; otherwise the tracker model supplies it.
  typedef struct {
    ptr_item_t   item;
    bit          typed;
    ptr_report_t report;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pct_in_if  feed_if ();
  pct_out_if report_if ();

  pointer_contact_tracker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (feed_if),
    .out_o  (report_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Tracker model: one slot per identifier, plus the handle counter.
  // ---------------------------------------------------------------------
  bit                      live_q    [ID_COUNT];
  logic [HANDLE_W-1:0]     handle_q  [ID_COUNT];
  ptype_e                  ptype_q   [ID_COUNT];
  kind_e                   kind_q    [ID_COUNT];
  logic [PAYLOAD_BITS-1:0] payload_q [ID_COUNT];
  logic [HANDLE_W-1:0]     handle_ctr;

  // Results still owed by the tracker, oldest first.
  ptr_report_t pending_reports[$];

  int mismatch_cnt = 0;
  int idle_cycles  = 0;
  bit steady_flow  = 1'b0;  // no idling on either side
  bit hold_req     = 1'b0;  // asks the result side for the long hold

  function automatic ptr_report_t entry_report(status_e st, int idx);
    ptr_report_t r;
    r         = '0;
    r.status  = st;
    r.handle  = handle_q[idx];
    r.ptype   = ptype_q[idx];
    r.kind    = kind_q[idx];
    r.payload = OPAY_W'(payload_q[idx]);
    return r;
  endfunction

  // Applies one accepted item to the model and returns the result it owes.
  function automatic ptr_report_t track_pointer(ptr_item_t it);
    ptr_report_t             r;
    int                      idx;
    logic [PAYLOAD_BITS-1:0] pay;
    r        = '0;
    r.status = STAT_IGNORED;
    idx      = int'(it.ident);
    pay      = it.payload[PAYLOAD_BITS-1:0];
    case (it.mode)
      MODE_EVENT: begin
        if (idx < ID_COUNT) begin
          if (!live_q[idx]) begin
            // Only touch start, mouse down and hover open a slot.
            if (it.kind == K_TOUCH_START || it.kind == K_MOUSE_DOWN ||
                it.kind == K_HOVER_MOVE) begin
              live_q[idx]    = 1'b1;
              handle_q[idx]  = handle_ctr;
              handle_ctr     = handle_ctr + 1'b1;  // wraps modulo 2^32
              ptype_q[idx]   = (it.kind == K_TOUCH_START) ? PT_TOUCH :
                               (it.kind == K_MOUSE_DOWN)  ? PT_MOUSE : PT_NONE;
              kind_q[idx]    = it.kind;
              payload_q[idx] = pay;
              r = entry_report(STAT_INSERTED, idx);
            end
          end else if (it.kind != K_TOUCH_START && it.kind != K_MOUSE_DOWN) begin
            // Live slot: everything but a second start overwrites the last event.
            kind_q[idx]    = it.kind;
            payload_q[idx] = pay;
            r = entry_report(STAT_UPDATED, idx);
          end
        end
      end
      MODE_SWEEP: begin
        r.status = STAT_SWEPT;
        for (int i = 0; i < ID_COUNT; i++) begin
          if (live_q[i] && (kind_q[i] == K_TOUCH_END || kind_q[i] == K_TOUCH_CANCEL ||
                            kind_q[i] == K_MOUSE_UP)) begin
            live_q[i] = 1'b0;
            r.removed = r.removed + 1'b1;
          end
        end
      end
      MODE_QUERY: begin
        if (idx < ID_COUNT && live_q[idx]) r = entry_report(STAT_HIT, idx);
        else r.status = STAT_MISS;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random item shaped as pointer life cycles: open absent identifiers,
  // move or close live ones, with some noise, sweeps, queries and mode 3.
  // Identifiers mostly come from a small pool so that slots get reused.
  function automatic ptr_item_t random_item();
    ptr_item_t it;
    int        pick;
    pick       = $urandom_range(0, 99);
    it.ident   = ($urandom_range(0, 3) == 0) ? IDENT_W'($urandom_range(0, (1 << IDENT_W) - 1))
                                             : IDENT_W'($urandom_range(0, 15));
    it.payload = $urandom();
    it.kind    = kind_e'($urandom_range(0, 7));
    if (pick < 5) begin
      it.mode = MODE_SWEEP;
    end else if (pick < 25) begin
      it.mode = MODE_QUERY;
    end else if (pick < 27) begin
      it.mode = MODE_UNUSED;
    end else begin
      it.mode = MODE_EVENT;
      if ($urandom_range(0, 4) != 0) begin
        if (!live_q[it.ident]) begin
          case ($urandom_range(0, 2))
            0:       it.kind = K_TOUCH_START;
            1:       it.kind = K_MOUSE_DOWN;
            default: it.kind = K_HOVER_MOVE;
          endcase
        end else begin
          case ($urandom_range(0, 7))
            0, 1:    it.kind = K_TOUCH_MOVE;
            2, 3:    it.kind = K_MOUSE_MOVE;
            4:       it.kind = K_HOVER_MOVE;
            5:       it.kind = K_TOUCH_END;
            6:       it.kind = K_TOUCH_CANCEL;
            default: it.kind = K_MOUSE_UP;
          endcase
        end
      end
    end
    return it;
  endfunction

  function automatic dir_row_t stim_row(logic [MODE_W-1:0] m, kind_e k, int id,
                                        logic [OPAY_W-1:0] p);
    dir_row_t row;
    row.item.mode    = m;
    row.item.kind    = k;
    row.item.ident   = IDENT_W'(id);
    row.item.payload = p;
    row.typed        = 1'b0;
    row.report       = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(dir_row_t row, status_e st,
                                         logic [HANDLE_W-1:0] h, ptype_e pt, kind_e k,
                                         logic [OPAY_W-1:0] p, logic [COUNT_W-1:0] n);
    row.typed          = 1'b1;
    row.report.status  = st;
    row.report.handle  = h;
    row.report.ptype   = pt;
    row.report.kind    = k;
    row.report.payload = p;
    row.report.removed = n;
    return row;
  endfunction

  // Offers one item from a falling edge, holds it until the transfer, then
  // books the owed result. Returns at the falling edge after the transfer
  // with valid still high, so back-to-back items keep valid asserted.
  task automatic offer_item(ptr_item_t it, bit typed, ptr_report_t typed_rep);
    ptr_report_t owed;
    if (!steady_flow && $urandom_range(0, 7) == 0) begin
      feed_if.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    feed_if.valid         = 1'b1;
    feed_if.mode          = it.mode;
    feed_if.event_kind    = it.kind;
    feed_if.identifier    = it.ident;
    feed_if.event_payload = it.payload;
    do @(posedge clk_i); while (!feed_if.ready);
    owed = track_pointer(it);
    pending_reports.push_back(typed ? typed_rep : owed);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, the long hold on request, and a
  // steady ready in the last part of the run.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    report_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        report_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!steady_flow && $urandom_range(0, 9) == 0) begin
        report_if.ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end else begin
        report_if.ready = 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // Scoreboard: every result transfer against the oldest owed result.
  always @(posedge clk_i) begin : check_reports
    ptr_report_t seen;
    ptr_report_t want;
    if (rst_ni && report_if.valid && report_if.ready) begin
      seen.status  = status_e'(report_if.status);
      seen.handle  = report_if.handle;
      seen.ptype   = ptype_e'(report_if.pointer_type);
      seen.kind    = kind_e'(report_if.last_kind);
      seen.payload = report_if.last_payload;
      seen.removed = report_if.removed_count;
      if (pending_reports.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("%0t: unexpected result, status %0d", $time, report_if.status);
      end else begin
        want = pending_reports.pop_front();
        if (seen.status !== want.status || seen.handle !== want.handle ||
            seen.ptype !== want.ptype || seen.kind !== want.kind ||
            seen.payload !== want.payload || seen.removed !== want.removed) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("%0t: mismatch exp st=%0d h=%h pt=%0d k=%0d p=%h n=%0d", $time,
                     want.status, want.handle, want.ptype, want.kind, want.payload,
                     want.removed);
            $display("%0t:          got st=%0d h=%h pt=%0d k=%0d p=%h n=%0d", $time,
                     report_if.status, report_if.handle, report_if.pointer_type,
                     report_if.last_kind, report_if.last_payload, report_if.removed_count);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (feed_if.valid && feed_if.ready) ||
        (report_if.valid && report_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: reset, directed table, then random traffic in phases.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    rows[$];
    ptr_report_t none;
    none                  = '0;
    rst_ni                = 1'b0;
    feed_if.valid         = 1'b0;
    feed_if.mode          = '0;
    feed_if.event_kind    = '0;
    feed_if.identifier    = '0;
    feed_if.event_payload = '0;
    handle_ctr            = HANDLE_W'(1);
    for (int i = 0; i < ID_COUNT; i++) live_q[i] = 1'b0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table: query misses, sweep drops nothing, stray move and mode 3
    // are ignored. All-zero fields use the zero kind code.
    rows.push_back(typed_row(stim_row(MODE_QUERY, K_TOUCH_START, 0, '0),
                             STAT_MISS, '0, PT_NONE, K_TOUCH_START, '0, '0));
    rows.push_back(typed_row(stim_row(MODE_SWEEP, K_TOUCH_START, 0, '0),
                             STAT_SWEPT, '0, PT_NONE, K_TOUCH_START, '0, '0));
    rows.push_back(typed_row(stim_row(MODE_EVENT, K_TOUCH_MOVE, 5, '1),
                             STAT_IGNORED, '0, PT_NONE, K_TOUCH_START, '0, '0));
    rows.push_back(typed_row(stim_row(MODE_UNUSED, K_HOVER_MOVE, 255, '1),
                             STAT_IGNORED, '0, PT_NONE, K_TOUCH_START, '0, '0));
    // One slot of each pointer type; handles count up from one.
    rows.push_back(typed_row(stim_row(MODE_EVENT, K_TOUCH_START, 0, '0),
                             STAT_INSERTED, 32'd1, PT_TOUCH, K_TOUCH_START, '0, '0));
    rows.push_back(typed_row(stim_row(MODE_EVENT, K_MOUSE_DOWN, 255, '1),
                             STAT_INSERTED, 32'd2, PT_MOUSE, K_MOUSE_DOWN, '1, '0));
    rows.push_back(typed_row(stim_row(MODE_EVENT, K_HOVER_MOVE, 128, 32'h5555_AAAA),
                             STAT_INSERTED, 32'd3, PT_NONE, K_HOVER_MOVE, 32'h5555_AAAA, '0));
    // A second start on a live slot changes nothing.
    rows.push_back(typed_row(stim_row(MODE_EVENT, K_TOUCH_START, 0, 32'h1234),
                             STAT_IGNORED, '0, PT_NONE, K_TOUCH_START, '0, '0));
    rows.push_back(typed_row(stim_row(MODE_EVENT, K_MOUSE_DOWN, 255, 32'h1234),
                             STAT_IGNORED, '0, PT_NONE, K_TOUCH_START, '0, '0));
    // Hover on a live slot, moves and a query, then close all three, sweep and query.
    rows.push_back(stim_row(MODE_EVENT, K_HOVER_MOVE, 128, 32'hAAAA_5555));
    rows.push_back(stim_row(MODE_EVENT, K_TOUCH_MOVE, 0, '1));
    rows.push_back(stim_row(MODE_EVENT, K_MOUSE_MOVE, 255, '0));
    rows.push_back(stim_row(MODE_QUERY, K_MOUSE_UP, 0, '1));
    rows.push_back(stim_row(MODE_EVENT, K_TOUCH_END, 0, 32'h0F0F_0F0F));
    rows.push_back(stim_row(MODE_EVENT, K_MOUSE_UP, 255, 32'hF0F0_F0F0));
    rows.push_back(stim_row(MODE_EVENT, K_TOUCH_CANCEL, 128, 32'h8000_0001));
    rows.push_back(stim_row(MODE_QUERY, K_TOUCH_START, 255, '0));
    rows.push_back(stim_row(MODE_SWEEP, K_HOVER_MOVE, 77, '1));
    rows.push_back(stim_row(MODE_QUERY, K_TOUCH_START, 128, '0));
    // Close on an absent slot is ignored; a hover after an up keeps the slot.
    rows.push_back(typed_row(stim_row(MODE_EVENT, K_MOUSE_UP, 7, '1),
                             STAT_IGNORED, '0, PT_NONE, K_TOUCH_START, '0, '0));
    rows.push_back(stim_row(MODE_EVENT, K_TOUCH_START, 7, 32'h0000_0007));
    rows.push_back(stim_row(MODE_EVENT, K_MOUSE_UP, 7, 32'h7000_0000));
    rows.push_back(stim_row(MODE_EVENT, K_HOVER_MOVE, 7, 32'h7777_7777));
    rows.push_back(stim_row(MODE_SWEEP, K_TOUCH_START, 0, '0));
    rows.push_back(stim_row(MODE_QUERY, K_TOUCH_START, 7, '0));

    foreach (rows[i]) offer_item(rows[i].item, rows[i].typed, rows[i].report);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Long result-side hold while items keep coming: the tracker fills up.
      if (n == RANDOM_ITEMS * 3 / 10) hold_req = 1'b1;
      // Sender pause until every owed result is back.
      if (n == RANDOM_ITEMS / 2) begin
        feed_if.valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge clk_i);
      end
      if (n == RANDOM_ITEMS * 4 / 5) steady_flow = 1'b1;
      offer_item(random_item(), 1'b0, none);
    end

    feed_if.valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- pointer_contact_tracker.f -----
+incdir+rtl
rtl/pct_pkg.sv
rtl/pct_intf.sv
rtl/pointer_contact_tracker.sv
sim/tb_pointer_contact_tracker.sv
